/* rtl/conv2d_3x3_valid_stream_core_assert.svh */
// Assertion macros shared by the convolution core files.
`ifndef CONV2D_3X3_VALID_STREAM_CORE_ASSERT_SVH
`define CONV2D_3X3_VALID_STREAM_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define C2D_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define C2D_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/c2d_pkg.sv */
package c2d_pkg;

  localparam int unsigned MaxWidth   = 2048;
  localparam int unsigned MaxHeight  = 4096;
  localparam int unsigned PixelBits  = 16;
  localparam int unsigned CoefBits   = 16;
  localparam int unsigned CoefSlot   = 16;
  localparam int unsigned KSize      = 3;
  localparam int unsigned Taps       = KSize * KSize;
  localparam int unsigned WinCols    = 2 * KSize;
  localparam int unsigned ColBits    = $clog2(MaxWidth);
  localparam int unsigned RowBits    = $clog2(MaxHeight);
  localparam int unsigned WidthBits  = 12;
  localparam int unsigned HeightBits = 13;
  localparam int unsigned CoefRowBits = 48;
  localparam int unsigned LineBits   = 2 * PixelBits;
  localparam int unsigned ProdBits   = PixelBits + CoefBits;
  localparam int unsigned PartBits   = ProdBits + 2;
  localparam int unsigned SumBits    = 35;
  localparam int unsigned AddrBits   = 6;
  localparam int unsigned DataBits   = 64;
  localparam int unsigned RegSelLsb  = 3;

  typedef enum logic [2:0] {
    RegWidth   = 3'd0,
    RegHeight  = 3'd1,
    RegCoefTop = 3'd2,
    RegCoefMid = 3'd3,
    RegCoefBot = 3'd4
  } c2d_reg_e;

  typedef struct packed {
    logic [WidthBits-1:0]             width;
    logic [HeightBits-1:0]            height;
    logic [Taps-1:0][CoefBits-1:0]    coef;
  } c2d_cfg_t;

  typedef struct packed {
    logic                             vld;
    logic                             full;
    logic                             row_end;
    logic                             image_end;
    logic [Taps-1:0][PixelBits-1:0]   tap;
  } c2d_win_t;

endpackage

/* rtl/conv2d_3x3_valid_stream_core.sv */
// A pixel that completes a window passes through the window register, the product register,
// the row partial-sum register and the sum register before its result is valid on the output.
// Throughput: one pixel per cycle, set by the single line-buffer RAM that is read and
// written once per pixel; the pipeline holds as a whole only while a result waits.
// Reset clears counters, window and valid flags; line-buffer contents stay undefined
// and need no clearing pass, so pixels are accepted from the first cycle after reset.
`include "conv2d_3x3_valid_stream_core_assert.svh"

module conv2d_3x3_valid_stream_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [c2d_pkg::PixelBits-1:0] pixel_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [c2d_pkg::SumBits-1:0]   conv_sum_o,
  output logic                                 row_end_o,
  output logic                                 image_end_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [c2d_pkg::AddrBits-1:0]         paddr,
  input  logic [c2d_pkg::DataBits-1:0]         pwdata,
  output logic [c2d_pkg::DataBits-1:0]         prdata,
  output logic                                 pready
);

  c2d_pkg::c2d_cfg_t cfg;
  c2d_pkg::c2d_win_t win;
  logic              en;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  c2d_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  c2d_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .pixel_i    (pixel_i),
    .win_o      (win)
  );

  c2d_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .win_i       (win),
    .coef_i      (cfg.coef),
    .out_valid_o (out_valid_o),
    .conv_sum_o  (conv_sum_o),
    .row_end_o   (row_end_o),
    .image_end_o (image_end_o)
  );

  `C2D_ASSERT_IMP(a_stall_only_on_waiting_result, clk_i, rst_ni, in_stall_o, out_valid_o)

endmodule

/* rtl/c2d_ram.sv */
module c2d_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/c2d_cfg.sv */
module c2d_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [c2d_pkg::AddrBits-1:0]     paddr,
  input  logic [c2d_pkg::DataBits-1:0]     pwdata,
  output logic [c2d_pkg::DataBits-1:0]     prdata,
  output logic                             pready,
  output c2d_pkg::c2d_cfg_t                cfg_o
);

  logic [c2d_pkg::WidthBits-1:0]   width_q, width_d;
  logic [c2d_pkg::HeightBits-1:0]  height_q, height_d;
  logic [c2d_pkg::CoefRowBits-1:0] coef_q [c2d_pkg::KSize];
  logic [c2d_pkg::CoefRowBits-1:0] coef_d [c2d_pkg::KSize];
  c2d_pkg::c2d_reg_e               sel;
  logic                            wr;

  assign pready = 1'b1;
  assign sel    = c2d_pkg::c2d_reg_e'(paddr[c2d_pkg::AddrBits-1:c2d_pkg::RegSelLsb]);
  assign wr     = psel && penable && pwrite && pready;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    coef_d   = coef_q;
    if (wr) begin
      case (sel)
        c2d_pkg::RegWidth:   width_d   = pwdata[c2d_pkg::WidthBits-1:0];
        c2d_pkg::RegHeight:  height_d  = pwdata[c2d_pkg::HeightBits-1:0];
        c2d_pkg::RegCoefTop: coef_d[0] = pwdata[c2d_pkg::CoefRowBits-1:0];
        c2d_pkg::RegCoefMid: coef_d[1] = pwdata[c2d_pkg::CoefRowBits-1:0];
        c2d_pkg::RegCoefBot: coef_d[2] = pwdata[c2d_pkg::CoefRowBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= c2d_pkg::WidthBits'(c2d_pkg::MaxWidth);
      height_q <= c2d_pkg::HeightBits'(c2d_pkg::MaxHeight);
      for (int i = 0; i < c2d_pkg::KSize; i++) begin
        coef_q[i] <= '0;
      end
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      coef_q   <= coef_d;
    end
  end

  always_comb begin
    case (sel)
      c2d_pkg::RegWidth:   prdata = c2d_pkg::DataBits'(width_q);
      c2d_pkg::RegHeight:  prdata = c2d_pkg::DataBits'(height_q);
      c2d_pkg::RegCoefTop: prdata = c2d_pkg::DataBits'(coef_q[0]);
      c2d_pkg::RegCoefMid: prdata = c2d_pkg::DataBits'(coef_q[1]);
      c2d_pkg::RegCoefBot: prdata = c2d_pkg::DataBits'(coef_q[2]);
      default:             prdata = '0;
    endcase
  end

  always_comb begin
    if (width_q < c2d_pkg::WidthBits'(c2d_pkg::KSize)) begin
      cfg_o.width = c2d_pkg::WidthBits'(c2d_pkg::KSize);
    end else if (width_q > c2d_pkg::WidthBits'(c2d_pkg::MaxWidth)) begin
      cfg_o.width = c2d_pkg::WidthBits'(c2d_pkg::MaxWidth);
    end else begin
      cfg_o.width = width_q;
    end
    if (height_q < c2d_pkg::HeightBits'(c2d_pkg::KSize)) begin
      cfg_o.height = c2d_pkg::HeightBits'(c2d_pkg::KSize);
    end else if (height_q > c2d_pkg::HeightBits'(c2d_pkg::MaxHeight)) begin
      cfg_o.height = c2d_pkg::HeightBits'(c2d_pkg::MaxHeight);
    end else begin
      cfg_o.height = height_q;
    end
    for (int ki = 0; ki < c2d_pkg::KSize; ki++) begin
      for (int kj = 0; kj < c2d_pkg::KSize; kj++) begin
        cfg_o.coef[ki*c2d_pkg::KSize+kj] =
          coef_q[ki][kj*c2d_pkg::CoefSlot +: c2d_pkg::CoefBits];
      end
    end
  end

endmodule

/* rtl/c2d_window.sv */
`include "conv2d_3x3_valid_stream_core_assert.svh"

module c2d_window (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  c2d_pkg::c2d_cfg_t               cfg_i,
  input  logic                            en_i,
  input  logic                            in_valid_i,
  input  logic [c2d_pkg::PixelBits-1:0]   pixel_i,
  output c2d_pkg::c2d_win_t               win_o
);

  logic                              acc;
  logic                              last_col, last_row;
  logic [c2d_pkg::ColBits-1:0]       col_q, col_d;
  logic [c2d_pkg::RowBits-1:0]       row_q, row_d;
  logic                              v1_q, v1_d;
  logic [c2d_pkg::ColBits-1:0]       addr1_q;
  logic [c2d_pkg::PixelBits-1:0]     px1_q;
  logic                              full1_q, lc1_q, lr1_q;
  logic [c2d_pkg::PixelBits-1:0]     wc_q [c2d_pkg::WinCols];
  logic [c2d_pkg::PixelBits-1:0]     cur [c2d_pkg::KSize];
  logic                              ram_we;
  logic [c2d_pkg::LineBits-1:0]      ram_rdata;

  assign acc      = in_valid_i && en_i;
  assign last_col = ({1'b0, col_q} + c2d_pkg::WidthBits'(1)) >= cfg_i.width;
  assign last_row = ({1'b0, row_q} + c2d_pkg::HeightBits'(1)) >= cfg_i.height;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (acc) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + c2d_pkg::RowBits'(1);
      end else begin
        col_d = col_q + c2d_pkg::ColBits'(1);
      end
    end
    v1_d = en_i ? acc : v1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      v1_q  <= 1'b0;
      for (int i = 0; i < c2d_pkg::WinCols; i++) begin
        wc_q[i] <= '0;
      end
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      v1_q  <= v1_d;
      if (ram_we) begin
        for (int i = 0; i < c2d_pkg::KSize; i++) begin
          wc_q[i]                 <= wc_q[c2d_pkg::KSize+i];
          wc_q[c2d_pkg::KSize+i]  <= cur[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      addr1_q <= col_q;
      px1_q   <= pixel_i;
      full1_q <= (col_q >= c2d_pkg::ColBits'(2)) && (row_q >= c2d_pkg::RowBits'(2));
      lc1_q   <= last_col;
      lr1_q   <= last_row;
    end
  end

  // Each entry holds the row two above in the upper half and the row one above in the lower.
  assign ram_we = v1_q && en_i;

  c2d_ram #(
    .Width (c2d_pkg::LineBits),
    .Depth (c2d_pkg::MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr1_q),
    .wdata_i ({cur[1], px1_q}),
    .re_i    (acc),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  assign cur[0] = ram_rdata[c2d_pkg::LineBits-1:c2d_pkg::PixelBits];
  assign cur[1] = ram_rdata[c2d_pkg::PixelBits-1:0];
  assign cur[2] = px1_q;

  always_comb begin
    win_o.vld       = v1_q;
    win_o.full      = full1_q;
    win_o.row_end   = lc1_q;
    win_o.image_end = lc1_q && lr1_q;
    for (int ki = 0; ki < c2d_pkg::KSize; ki++) begin
      win_o.tap[ki*c2d_pkg::KSize+0] = wc_q[ki];
      win_o.tap[ki*c2d_pkg::KSize+1] = wc_q[c2d_pkg::KSize+ki];
      win_o.tap[ki*c2d_pkg::KSize+2] = cur[ki];
    end
  end

  `C2D_ASSERT_IMP(a_no_same_entry, clk_i, rst_ni, ram_we && acc, addr1_q != col_q)
  `C2D_ASSERT_NEXT(a_held_item, clk_i, rst_ni, v1_q && !en_i, v1_q && $stable(addr1_q))

endmodule

/* rtl/c2d_mac.sv */
`include "conv2d_3x3_valid_stream_core_assert.svh"

module c2d_mac (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        en_i,
  input  c2d_pkg::c2d_win_t                           win_i,
  input  logic [c2d_pkg::Taps-1:0][c2d_pkg::CoefBits-1:0] coef_i,
  output logic                                        out_valid_o,
  output logic signed [c2d_pkg::SumBits-1:0]          conv_sum_o,
  output logic                                        row_end_o,
  output logic                                        image_end_o
);

  logic                                  load2;
  logic                                  v2_q, v2_d, v3_q, v3_d, vo_q, vo_d;
  logic signed [c2d_pkg::ProdBits-1:0]   prod_d [c2d_pkg::Taps];
  logic signed [c2d_pkg::ProdBits-1:0]   prod_q [c2d_pkg::Taps];
  logic signed [c2d_pkg::PartBits-1:0]   part_d [c2d_pkg::KSize];
  logic signed [c2d_pkg::PartBits-1:0]   part_q [c2d_pkg::KSize];
  logic signed [c2d_pkg::SumBits-1:0]    sum_d, sum_q;
  logic                                  re2_q, ie2_q, re3_q, ie3_q, reo_q, ieo_q;

  assign load2 = en_i && win_i.vld && win_i.full;

  always_comb begin
    for (int i = 0; i < c2d_pkg::Taps; i++) begin
      prod_d[i] = $signed({{c2d_pkg::CoefBits{win_i.tap[i][c2d_pkg::PixelBits-1]}},
                           win_i.tap[i]})
                * $signed({{c2d_pkg::PixelBits{coef_i[i][c2d_pkg::CoefBits-1]}},
                           coef_i[i]});
    end
    for (int k = 0; k < c2d_pkg::KSize; k++) begin
      part_d[k] = c2d_pkg::PartBits'(prod_q[k*c2d_pkg::KSize+0])
                + c2d_pkg::PartBits'(prod_q[k*c2d_pkg::KSize+1])
                + c2d_pkg::PartBits'(prod_q[k*c2d_pkg::KSize+2]);
    end
    sum_d = c2d_pkg::SumBits'(part_q[0]) + c2d_pkg::SumBits'(part_q[1])
          + c2d_pkg::SumBits'(part_q[2]);
    v2_d = en_i ? (win_i.vld && win_i.full) : v2_q;
    v3_d = en_i ? v2_q : v3_q;
    vo_d = en_i ? v3_q : vo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v2_q <= v2_d;
      v3_q <= v3_d;
      vo_q <= vo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load2) begin
      prod_q <= prod_d;
      re2_q  <= win_i.row_end;
      ie2_q  <= win_i.image_end;
    end
    if (en_i && v2_q) begin
      part_q <= part_d;
      re3_q  <= re2_q;
      ie3_q  <= ie2_q;
    end
    if (en_i && v3_q) begin
      sum_q  <= sum_d;
      reo_q  <= re3_q;
      ieo_q  <= ie3_q;
    end
  end

  assign out_valid_o = vo_q;
  assign conv_sum_o  = sum_q;
  assign row_end_o   = reo_q;
  assign image_end_o = ieo_q;

  `C2D_ASSERT_IMP(a_image_end_ends_row, clk_i, rst_ni, out_valid_o && image_end_o, row_end_o)

endmodule
